>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types for the cell chain of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_mode_e;

  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } slot_t;

  typedef struct packed {
    cell_mode_e               mode;
    logic signed [ValueW-1:0] new_value;
    logic signed [PrioW-1:0]  new_prio;
  } cell_ctrl_t;

endpackage

>>> rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Fixed-capacity priority queue kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// The queue keeps up to CAPACITY entries sorted by ascending signed priority,
// earlier inserts first among equal priorities. Each request carries its
// operation in s_axis_tuser: insert, delete head or list all entries. Insert
// and delete each act on the whole chain in parallel, as every cell compares
// against the new priority and shifts, and give one response. A list request
// gives one response per stored entry, one per cycle while the output is not
// stalled, by rotating the chain through its head cell, and takes no new
// request until the last response is registered. An insert on a full queue
// is dropped with status full; delete or list on an empty queue answers with
// status empty. Operation code 3 is taken and gives no response.
module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // new_value [31:0], new_priority [47:32]
  input  logic [1:0]  s_axis_tuser,   // op [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_value [31:0], out_priority [47:32]
  output logic [1:0]  m_axis_tuser,   // status [1:0]
  output logic        m_axis_tlast
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic StIdle = 1'b0;
  localparam logic StList = 1'b1;

  spq_pkg::slot_t     slots [CAPACITY];
  logic               keep  [CAPACITY];
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::op_e       op;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic            out_free, accept;
  logic            m_valid_q, m_valid_d;
  logic [47:0]     m_data_q, m_data_d;
  logic [1:0]      m_user_q, m_user_d;
  logic            m_last_q, m_last_d;

  assign op       = spq_pkg::op_e'(s_axis_tuser);
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  always_comb begin
    ctrl.mode      = spq_pkg::CELL_HOLD;
    ctrl.new_value = s_axis_tdata[31:0];
    ctrl.new_prio  = s_axis_tdata[47:32];
    state_d   = state_q;
    count_d   = count_q;
    remain_d  = remain_q;
    m_valid_d = out_free ? 1'b0 : m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    if (accept) begin
      m_data_d  = '0;
      m_last_d  = 1'b1;
      m_user_d  = spq_pkg::ST_OK;
      case (op)
        spq_pkg::OP_INSERT: begin
          m_valid_d = 1'b1;
          if (count_q == CntW'(CAPACITY)) begin
            m_user_d = spq_pkg::ST_FULL;
          end else begin
            ctrl.mode = spq_pkg::CELL_INSERT;
            count_d   = count_q + CntW'(1);
          end
        end
        spq_pkg::OP_DELETE: begin
          m_valid_d = 1'b1;
          if (count_q == '0) begin
            m_user_d = spq_pkg::ST_EMPTY;
          end else begin
            ctrl.mode = spq_pkg::CELL_SHIFT;
            count_d   = count_q - CntW'(1);
            m_data_d  = {slots[0].prio, slots[0].value};
          end
        end
        spq_pkg::OP_LIST: begin
          m_valid_d = 1'b1;
          if (count_q == '0) begin
            m_user_d = spq_pkg::ST_EMPTY;
          end else begin
            ctrl.mode = spq_pkg::CELL_ROTATE;
            m_data_d  = {slots[0].prio, slots[0].value};
            m_last_d  = (count_q == CntW'(1));
            remain_d  = count_q - CntW'(1);
            if (count_q != CntW'(1)) begin
              state_d = StList;
            end
          end
        end
        default: begin
          m_valid_d = 1'b0;
        end
      endcase
    end else if (state_q == StList && out_free) begin
      ctrl.mode = spq_pkg::CELL_ROTATE;
      m_valid_d = 1'b1;
      m_user_d  = spq_pkg::ST_OK;
      m_data_d  = {slots[0].prio, slots[0].value};
      m_last_d  = (remain_q == CntW'(1));
      remain_d  = remain_q - CntW'(1);
      if (remain_q == CntW'(1)) begin
        state_d = StIdle;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::slot_t left, right;
    logic           left_keep;
    if (i == 0) begin : g_first
      assign left      = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left      = slots[i-1];
      assign left_keep = keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = slots[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_keep_i (left_keep),
      .left_i      (left),
      .right_i     (right),
      .head_i      (slots[0]),
      .slot_o      (slots[i]),
      .keep_o      (keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      remain_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      remain_q  <= remain_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

endmodule

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain; holds, inserts, shifts or rotates its entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               left_keep_i,
  input  spq_pkg::slot_t     left_i,
  input  spq_pkg::slot_t     right_i,
  input  spq_pkg::slot_t     head_i,
  output spq_pkg::slot_t     slot_o,
  output logic               keep_o
);

  logic                             valid_q, valid_d;
  logic signed [spq_pkg::ValueW-1:0] value_q, value_d;
  logic signed [spq_pkg::PrioW-1:0]  prio_q, prio_d;

  assign keep_o = valid_q && (prio_q <= ctrl_i.new_prio);
  assign slot_o = '{valid: valid_q, value: value_q, prio: prio_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    case (ctrl_i.mode)
      spq_pkg::CELL_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            valid_d = 1'b1;
            value_d = ctrl_i.new_value;
            prio_d  = ctrl_i.new_prio;
          end else begin
            valid_d = left_i.valid;
            value_d = left_i.value;
            prio_d  = left_i.prio;
          end
        end
      end
      spq_pkg::CELL_SHIFT: begin
        valid_d = right_i.valid;
        value_d = right_i.value;
        prio_d  = right_i.prio;
      end
      spq_pkg::CELL_ROTATE: begin
        if (right_i.valid) begin
          value_d = right_i.value;
          prio_d  = right_i.prio;
        end else if (valid_q) begin
          value_d = head_i.value;
          prio_d  = head_i.prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Sends insert, delete, list and no-op requests with random idle cycles and
// back-pressure. Every response is predicted from a sorted copy of the stored
// entries kept here, and checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned QueueDepth     = 16;
  localparam int unsigned IdlePct        = 28;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned SettleCycles   = 40;
  localparam int unsigned RandomRequests = 330;

  typedef struct packed {
    logic signed [spq_pkg::ValueW-1:0] value;
    logic signed [spq_pkg::PrioW-1:0]  prio;
  } entry_t;

  typedef struct packed {
    spq_pkg::status_e                  status;
    logic signed [spq_pkg::ValueW-1:0] value;
    logic signed [spq_pkg::PrioW-1:0]  prio;
    logic                              last;
  } response_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  entry_t      stored_entries[$];
  response_t   pending_responses[$];
  response_t   oldest_response;
  bit          no_idle      = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  sorted_priority_queue_unit #(
    .CAPACITY(QueueDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic void predict_queue_responses(
    spq_pkg::op_e op,
    logic signed [spq_pkg::ValueW-1:0] value,
    logic signed [spq_pkg::PrioW-1:0] prio
  );
    int        pos;
    entry_t    swap;
    response_t resp;
    resp.status = spq_pkg::ST_OK;
    resp.value  = '0;
    resp.prio   = '0;
    resp.last   = 1'b1;
    case (op)
      spq_pkg::OP_INSERT: begin
        if (stored_entries.size() >= QueueDepth) begin
          resp.status = spq_pkg::ST_FULL;
        end else begin
          swap.value = value;
          swap.prio  = prio;
          stored_entries.push_back(swap);
          pos = stored_entries.size() - 1;
          // move ahead only past strictly larger priorities, keeping insert order on ties
          while (pos > 0 && stored_entries[pos-1].prio > prio) begin
            swap                  = stored_entries[pos-1];
            stored_entries[pos-1] = stored_entries[pos];
            stored_entries[pos]   = swap;
            pos--;
          end
        end
        pending_responses.push_back(resp);
      end
      spq_pkg::OP_DELETE: begin
        if (stored_entries.size() == 0) begin
          resp.status = spq_pkg::ST_EMPTY;
        end else begin
          swap       = stored_entries.pop_front();
          resp.value = swap.value;
          resp.prio  = swap.prio;
        end
        pending_responses.push_back(resp);
      end
      spq_pkg::OP_LIST: begin
        if (stored_entries.size() == 0) begin
          resp.status = spq_pkg::ST_EMPTY;
          pending_responses.push_back(resp);
        end else begin
          for (pos = 0; pos < stored_entries.size(); pos++) begin
            resp.value = stored_entries[pos].value;
            resp.prio  = stored_entries[pos].prio;
            resp.last  = (pos == stored_entries.size() - 1);
            pending_responses.push_back(resp);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_request(input spq_pkg::op_e op,
                              input logic signed [spq_pkg::ValueW-1:0] value,
                              input logic signed [spq_pkg::PrioW-1:0] prio);
    bit taken;
    taken = 1'b0;
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {prio, value};
    while (!taken) begin
      @(posedge clk_i);
      if (s_axis_tready) begin
        taken = 1'b1;
        predict_queue_responses(op, value, prio);
      end
      @(negedge clk_i);
    end
  endtask

  function automatic void check_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual status %0d value %0d",
                 $time, m_axis_tuser, $signed(m_axis_tdata[31:0]));
        mismatches++;
      end else begin
        oldest_response = pending_responses.pop_front();
        check_field("status", oldest_response.status, m_axis_tuser);
        check_field("value", oldest_response.value, $signed(m_axis_tdata[31:0]));
        check_field("priority", oldest_response.prio, $signed(m_axis_tdata[47:32]));
        check_field("last", oldest_response.last, m_axis_tlast);
      end
    end
  end

  always @(negedge clk_i) m_axis_tready = no_idle || ($urandom_range(99) >= IdlePct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_empty_queue();
    send_request(spq_pkg::OP_DELETE, 32'sd0, 16'sd0);
    send_request(spq_pkg::OP_LIST, 32'sd0, 16'sd0);
    send_request(spq_pkg::OP_NONE, 32'sd0, 16'sd0);
  endtask

  task automatic test_field_extremes();
    send_request(spq_pkg::OP_INSERT, 32'sh8000_0000, 16'sh7FFF);
    send_request(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 16'sh8000);
    send_request(spq_pkg::OP_INSERT, 32'sd0, 16'sd0);
    send_request(spq_pkg::OP_INSERT, 32'shFFFF_FFFF, 16'shFFFF);
    send_request(spq_pkg::OP_LIST, 32'sd0, 16'sd0);
  endtask

  task automatic test_fill_and_overflow();
    int i;
    for (i = 0; i < QueueDepth - 4; i++) begin
      send_request(spq_pkg::OP_INSERT, 32'(i + 1), 16'((i % 3) - 1));
    end
    send_request(spq_pkg::OP_INSERT, 32'sh5A5A_5A5A, 16'sh8000);
    send_request(spq_pkg::OP_LIST, 32'sd0, 16'sd0);
  endtask

  task automatic test_delete_head();
    send_request(spq_pkg::OP_DELETE, 32'sd0, 16'sd0);
    send_request(spq_pkg::OP_DELETE, 32'sd0, 16'sd0);
    send_request(spq_pkg::OP_NONE, 32'shFFFF_FFFF, 16'shFFFF);
  endtask

  task automatic test_random_traffic();
    int unsigned                      sent;
    int unsigned                      run_len;
    int unsigned                      insert_pct;
    int unsigned                      roll;
    spq_pkg::op_e                     op;
    logic signed [spq_pkg::PrioW-1:0] prio;
    sent = 0;
    while (sent < RandomRequests) begin
      case ($urandom_range(2))
        0:       insert_pct = 70;
        1:       insert_pct = 15;
        default: insert_pct = 45;
      endcase
      run_len = $urandom_range(4, 20);
      no_idle = (sent >= 120 && sent < 200);
      repeat (run_len) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          op = spq_pkg::OP_NONE;
        end else if (roll < 12) begin
          op = spq_pkg::OP_LIST;
        end else if (roll < 12 + insert_pct) begin
          op = spq_pkg::OP_INSERT;
        end else begin
          op = spq_pkg::OP_DELETE;
        end
        // narrow priorities half the time to force ties
        if ($urandom_range(1)) begin
          prio = 16'($urandom);
        end else begin
          prio = 16'(int'($urandom_range(6)) - 3);
        end
        send_request(op, $urandom, prio);
        if (op != spq_pkg::OP_NONE) begin
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_queue();
    test_field_extremes();
    test_fill_and_overflow();
    test_delete_head();
    test_random_traffic();
    s_axis_tvalid = 1'b0;
    while (pending_responses.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
